// File: rtl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg
// Shared types and constants of the low-bit payload extractor: transfer
// structs, controller command and status groups, result codes and the table
// of header slot counts.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int LENGTH_BITS  = 32;
    localparam int MAX_BPS      = 8;

    localparam int PAD_BITS  = ((LENGTH_BITS + 7) / 8) * 8;
    localparam int LEN_BYTES = PAD_BITS / 8;
    localparam int HSUM_W    = $clog2(LENGTH_BITS + MAX_BPS);
    localparam int HS_W      = $clog2(LENGTH_BITS + 1);
    localparam int CFG_W     = 32;
    localparam int CIDX_W    = 2;
    localparam int BPS_W     = 4;
    localparam int PROD_W    = CFG_W + BPS_W;

    localparam logic [CIDX_W-1:0] CFG_BITS_PER_SAMPLE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SAMPLE_COUNT      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 2'd2;

    localparam logic [2:0] RES_BYTE        = 3'd0;
    localparam logic [2:0] RES_EMPTY       = 3'd1;
    localparam logic [2:0] RES_HEADER_SHORT = 3'd2;
    localparam logic [2:0] RES_TOO_BIG     = 3'd3;
    localparam logic [2:0] RES_BODY_SHORT  = 3'd4;

    // Samples needed to carry the header, indexed by bits per sample minus one.
    localparam logic [HS_W-1:0] HSLOTS [MAX_BPS] = '{
        HS_W'((LENGTH_BITS + 0) / 1),
        HS_W'((LENGTH_BITS + 1) / 2),
        HS_W'((LENGTH_BITS + 2) / 3),
        HS_W'((LENGTH_BITS + 3) / 4),
        HS_W'((LENGTH_BITS + 4) / 5),
        HS_W'((LENGTH_BITS + 5) / 6),
        HS_W'((LENGTH_BITS + 6) / 7),
        HS_W'((LENGTH_BITS + 7) / 8)
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           start_req;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       step_hdr;
        logic       step_body;
        logic       chk;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic short_hdr;
        logic hdr_done;
        logic byte_done;
        logic byte_last;
        logic too_big;
        logic empty;
        logic body_short;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/lspe_dp.sv
// ----------------------------------------------------------------------------
// lspe_dp
// Datapath: configuration registers, sample latch, header and byte
// assembly, length checks and the result register.
// ----------------------------------------------------------------------------
module lspe_dp
    import lspe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  item_t             item,
    output result_t           result,
    output logic              result_valid,
    input  logic              result_ready,
    input  cmd_t              cmd,
    output sts_t              sts
);

    logic [BPS_W-1:0]       bps_reg;
    logic [CFG_W-1:0]       samples_reg;
    logic [CFG_W-1:0]       maxlen_reg;
    logic [7:0]             chunk_in_reg;
    logic                   start_reg;
    logic [LENGTH_BITS-1:0] hdr_bits_reg;
    logic [HSUM_W-1:0]      hdr_cnt_reg;
    logic [PAD_BITS-1:0]    len_reg;
    logic [7:0]             acc_reg;
    logic [2:0]             cnt_reg;
    logic [CFG_W-1:0]       emitted_reg;
    logic                   too_big_reg;
    logic                   empty_reg;
    logic                   under_reg;
    logic [PROD_W-1:0]      prod_reg;
    result_t                result_reg;
    logic                   result_valid_reg;

    logic [BPS_W-1:0]       n;
    logic [7:0]             mask;
    logic [7:0]             chunk;
    logic [HS_W-1:0]        hslots;
    logic [HSUM_W-1:0]      base_cnt;
    logic [LENGTH_BITS-1:0] base_bits;
    logic [HSUM_W-1:0]      hdr_sum;
    logic                   hdr_done;
    logic [HSUM_W-1:0]      k_wide;
    logic [BPS_W-1:0]       k;
    logic [7:0]             take;
    logic [LENGTH_BITS-1:0] hdr_next;
    logic [15:0]            comb_bits;
    logic [BPS_W-1:0]       total;
    logic [BPS_W-1:0]       spare;
    logic                   byte_done;
    logic [7:0]             byte_val;
    logic [7:0]             acc_next;
    logic [2:0]             cnt_next;
    logic                   byte_last;
    logic                   out_free;

    function automatic logic [PAD_BITS-1:0] decode_len(input logic [LENGTH_BITS-1:0] h);
        logic [PAD_BITS-1:0] v;
        logic [PAD_BITS-1:0] len;
        v   = PAD_BITS'(h) << (PAD_BITS - LENGTH_BITS);
        len = '0;
        for (int b = 0; b < LEN_BYTES; b++)
        begin
            len[8*b +: 8] = v[PAD_BITS - 8*(b+1) +: 8];
        end
        return len;
    endfunction

    always_comb
    begin
        if (bps_reg == '0)
        begin
            n = BPS_W'(1);
        end
        else if (bps_reg > BPS_W'(MAX_BPS))
        begin
            n = BPS_W'(MAX_BPS);
        end
        else
        begin
            n = bps_reg;
        end
    end

    assign mask   = 8'((9'd1 << n) - 9'd1);
    assign chunk  = chunk_in_reg & mask;
    assign hslots = HSLOTS[3'(n - BPS_W'(1))];

    // Header: the last header sample keeps only the bits that fill the header.
    assign base_cnt  = start_reg ? '0 : hdr_cnt_reg;
    assign base_bits = start_reg ? '0 : hdr_bits_reg;
    assign hdr_sum   = base_cnt + HSUM_W'(n);
    assign hdr_done  = hdr_sum >= HSUM_W'(LENGTH_BITS);
    assign k_wide    = HSUM_W'(LENGTH_BITS) - base_cnt;
    assign k         = hdr_done ? BPS_W'(k_wide) : n;
    assign take      = chunk >> (n - k);
    assign hdr_next  = (base_bits << k) | LENGTH_BITS'(take);

    // Body: at most one byte completes per sample.
    assign comb_bits = (16'(acc_reg) << n) | 16'(chunk);
    assign total     = BPS_W'(cnt_reg) + n;
    assign byte_done = total >= BPS_W'(8);
    assign spare     = total - BPS_W'(8);
    assign byte_val  = 8'(comb_bits >> spare);
    assign byte_last = ({1'b0, emitted_reg} + 33'd1) == 33'(len_reg);

    always_comb
    begin
        if (byte_done)
        begin
            acc_next = 8'(comb_bits & ((16'd1 << spare) - 16'd1));
            cnt_next = 3'(spare);
        end
        else
        begin
            acc_next = comb_bits[7:0];
            cnt_next = 3'(total);
        end
    end

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        sts            = '0;
        sts.start      = start_reg;
        sts.short_hdr  = samples_reg < CFG_W'(hslots);
        sts.hdr_done   = hdr_done;
        sts.byte_done  = byte_done;
        sts.byte_last  = byte_last;
        sts.too_big    = too_big_reg;
        sts.empty      = empty_reg;
        sts.body_short = under_reg || (PROD_W'({len_reg, 3'b000}) > prod_reg);
        sts.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg          <= BPS_W'(1);
            samples_reg      <= '0;
            maxlen_reg       <= '0;
            hdr_bits_reg     <= '0;
            hdr_cnt_reg      <= '0;
            len_reg          <= '0;
            acc_reg          <= '0;
            cnt_reg          <= '0;
            emitted_reg      <= '0;
            too_big_reg      <= 1'b0;
            empty_reg        <= 1'b0;
            under_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BITS_PER_SAMPLE:   bps_reg     <= cfg_data[BPS_W-1:0];
                    CFG_SAMPLE_COUNT:      samples_reg <= cfg_data;
                    CFG_MAX_PAYLOAD_BYTES: maxlen_reg  <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.step_hdr)
            begin
                hdr_bits_reg <= hdr_next;
                hdr_cnt_reg  <= hdr_sum;
                len_reg      <= decode_len(hdr_next);
            end
            if (cmd.chk)
            begin
                too_big_reg <= CFG_W'(len_reg) > maxlen_reg;
                empty_reg   <= len_reg == '0;
                under_reg   <= samples_reg < CFG_W'(hslots);
                acc_reg     <= '0;
                cnt_reg     <= '0;
                emitted_reg <= '0;
            end
            if (cmd.step_body)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
                if (byte_done)
                begin
                    emitted_reg <= emitted_reg + CFG_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chunk_in_reg <= item.sample[7:0];
            start_reg    <= item.start_req;
        end
        if (cmd.chk)
        begin
            prod_reg <= PROD_W'(samples_reg - CFG_W'(hslots)) * PROD_W'(n);
        end
        if (cmd.out_load)
        begin
            result_reg.payload_byte <= (cmd.out_status == RES_BYTE) ? byte_val : 8'd0;
            result_reg.status       <= cmd.out_status;
            result_reg.last         <= cmd.out_last;
        end
    end

    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result register loaded while a transfer is pending");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step_hdr, cmd.step_body, cmd.chk}))
        else $error("datapath given more than one action in a cycle");

    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> cnt_reg) == 8'd0)
        else $error("byte accumulator holds bits above its count");
`endif

endmodule

// File: rtl/lspe_ctrl.sv
// ----------------------------------------------------------------------------
// lspe_ctrl
// Controller: container phase and the per-sample sequence of accept, step,
// length check and result issue.
// ----------------------------------------------------------------------------
module lspe_ctrl
    import lspe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_STEP,
        ST_CHECK,
        ST_EVAL
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } phase_t;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_WAIT:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                priority if (sts.start && sts.short_hdr)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = RES_HEADER_SHORT;
                        cmd.out_last   = 1'b1;
                        phase_next     = PH_IDLE;
                        state_next     = ST_WAIT;
                    end
                end
                else if (sts.start || phase_reg == PH_HEADER)
                begin
                    cmd.step_hdr = 1'b1;
                    phase_next   = PH_HEADER;
                    state_next   = sts.hdr_done ? ST_CHECK : ST_WAIT;
                end
                else if (phase_reg == PH_BODY)
                begin
                    if (!sts.byte_done || sts.out_free)
                    begin
                        cmd.step_body = 1'b1;
                        state_next    = ST_WAIT;
                        if (sts.byte_done)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = RES_BYTE;
                            cmd.out_last   = sts.byte_last;
                            if (sts.byte_last)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_CHECK:
            begin
                cmd.chk    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.too_big || sts.empty || sts.body_short)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        priority if (sts.too_big)
                        begin
                            cmd.out_status = RES_TOO_BIG;
                        end
                        else if (sts.empty)
                        begin
                            cmd.out_status = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.out_status = RES_BODY_SHORT;
                        end
                        phase_next = PH_IDLE;
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    phase_next = PH_BODY;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eval_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (phase_reg == PH_HEADER))
        else $error("length check outside the header phase");

    a_short_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && sts.start && sts.short_hdr && sts.out_free)
        |=> (phase_reg == PH_IDLE && state_reg == ST_WAIT))
        else $error("short container did not end the container");
`endif

endmodule

// File: rtl/lsb_payload_extractor.sv
// ----------------------------------------------------------------------------
// lsb_payload_extractor
// Recovers a length-prefixed payload carried in the low bits of audio
// samples and reports the container's length errors.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Data
//  item      item_valid / item_ready    item.sample, item.start_req
//  result    result_valid / result_ready result.payload_byte, .status, .last
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  A sample is accepted in ST_WAIT, then steps the header or byte assembly
//  in ST_STEP. The sample that completes the header goes on to ST_CHECK,
//  which registers remaining samples times bits per sample, and ST_EVAL for
//  the length checks. A result waits in an output register while the next
//  sample is accepted; a new result stalls the step until it is taken.
//  Asynchronous reset clears state, phase, counters, flags and configuration.
// ----------------------------------------------------------------------------
module lsb_payload_extractor
    import lspe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    lspe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    lspe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// File: tb/lspe_checker.sv
// ----------------------------------------------------------------------------
// lspe_checker
// Watches the sample, result and register channels of the low-bit payload
// extractor. It keeps its own copy of the registers and extraction state,
// works out the result of every accepted sample, and compares each accepted
// result with the oldest one still due.
// ----------------------------------------------------------------------------
module lspe_checker
    import lspe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  item_t             item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  result_t           result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                failures,
    output int                pending,
    output int                bytes_seen,
    output int                reports_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ST_IDLE, ST_HDR, ST_BODY} extract_phase_t;

    extract_phase_t phase;
    logic [BPS_W-1:0] bps_reg;
    logic [31:0]      count_reg;
    logic [31:0]      cap_reg;
    logic [31:0]      hdr_sr;
    int unsigned      hdr_cnt;
    logic [31:0]      pay_len;
    logic [7:0]       acc;
    int unsigned      acc_cnt;
    logic [31:0]      emitted;

    result_t due_results[$];
    result_t want;
    result_t got;
    bit      has_result;

    function automatic bit extract_step(input item_t it, output result_t r);
        int unsigned n;
        int unsigned hs;
        int unsigned i;
        logic [7:0]  chunk;
        logic        b_in;
        logic [63:0] need;
        bit          produced;
        produced = 1'b0;
        r = '0;
        n = (bps_reg == 0) ? 1 : (bps_reg > MAX_BPS) ? MAX_BPS : bps_reg;
        hs = (LENGTH_BITS + n - 1) / n;
        chunk = it.sample[7:0] & ~(8'hFF << n);
        if (it.start_req) begin
            phase = ST_HDR;
            hdr_sr = '0;
            hdr_cnt = 0;
            pay_len = '0;
            acc = '0;
            acc_cnt = 0;
            emitted = '0;
            if (count_reg < hs) begin
                phase = ST_IDLE;
                r.status = RES_HEADER_SHORT;
                r.last = 1'b1;
                return 1'b1;
            end
        end
        if (phase == ST_IDLE) return 1'b0;
        for (i = n; i > 0; i--) begin
            b_in = chunk[i-1];
            if (phase == ST_HDR) begin
                hdr_sr = {hdr_sr[30:0], b_in};
                hdr_cnt++;
                if (hdr_cnt == LENGTH_BITS) begin
                    // The first header byte is the least significant one.
                    pay_len = {hdr_sr[7:0], hdr_sr[15:8], hdr_sr[23:16], hdr_sr[31:24]};
                    need = 64'(hs) + (64'(pay_len) * 8 + n - 1) / n;
                    if (pay_len > cap_reg) r.status = RES_TOO_BIG;
                    else if (pay_len == 0) r.status = RES_EMPTY;
                    else if (need > 64'(count_reg)) r.status = RES_BODY_SHORT;
                    else begin
                        phase = ST_BODY;
                        return 1'b0;
                    end
                    phase = ST_IDLE;
                    r.last = 1'b1;
                    return 1'b1;
                end
            end else begin
                acc = {acc[6:0], b_in};
                acc_cnt++;
                if (acc_cnt == 8) begin
                    r.payload_byte = acc;
                    r.status = RES_BYTE;
                    produced = 1'b1;
                    acc = '0;
                    acc_cnt = 0;
                    emitted++;
                    if (emitted >= pay_len) begin
                        r.last = 1'b1;
                        phase = ST_IDLE;
                        return 1'b1;
                    end
                end
            end
        end
        return produced;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase = ST_IDLE;
            bps_reg = 4'd1;
            count_reg = '0;
            cap_reg = '0;
            hdr_sr = '0;
            hdr_cnt = 0;
            pay_len = '0;
            acc = '0;
            acc_cnt = 0;
            emitted = '0;
            due_results.delete();
            failures = 0;
            pending = 0;
            bytes_seen = 0;
            reports_seen = 0;
        end else begin
            if (result_valid && result_ready) begin
                got = result;
                if (due_results.size() == 0) begin
                    $display("%0t lspe_checker: unexpected result, expected none,",
                             $realtime);
                    $display("    got byte %02h status %0d last %0d",
                             got.payload_byte, got.status, got.last);
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    if (got.payload_byte !== want.payload_byte || got.status !== want.status
                        || got.last !== want.last) begin
                        $display("%0t lspe_checker: mismatch, expected byte %02h status %0d",
                                 $realtime, want.payload_byte, want.status);
                        $display("    last %0d, got byte %02h status %0d last %0d",
                                 want.last, got.payload_byte, got.status, got.last);
                        failures++;
                    end
                    if (want.status == RES_BYTE) bytes_seen++;
                    else reports_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BITS_PER_SAMPLE:   bps_reg = cfg_data[BPS_W-1:0];
                    CFG_SAMPLE_COUNT:      count_reg = cfg_data;
                    CFG_MAX_PAYLOAD_BYTES: cap_reg = cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && item_ready) begin
                has_result = extract_step(item, want);
                if (has_result) due_results.push_back(want);
            end
            pending = due_results.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the low-bit payload extractor. Containers are
// built as sample streams that carry a length header and a random payload
// in their low bits, under many register settings, with empty, oversized,
// short and abandoned containers mixed in. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import lspe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1600;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    item_t             item;
    logic              result_valid;
    logic              result_ready;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int failures;
    int pending;
    int bytes_seen;
    int reports_seen;

    int          items_sent;
    int          containers;
    int          settings;
    int          burst_left;
    int          quiet_cycles;
    bit          gaps_on;
    int unsigned cur_n;
    logic [31:0] sc_cfg;
    logic [31:0] cap_cfg;

    lsb_payload_extractor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lspe_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending),
        .bytes_seen   (bytes_seen),
        .reports_seen (reports_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : receiver
        int unsigned rx_mode;
        int unsigned rx_hold;
        int unsigned rx_cycle;
        result_ready = 1'b0;
        rx_mode = 0;
        rx_hold = 0;
        rx_cycle = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
            if (rx_hold != 0)
            begin
                rx_hold--;
                result_ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: result_ready = 1'b1;
                    1: result_ready = $urandom_range(0, 1);
                    default:
                    begin
                        result_ready = ($urandom_range(0, 5) != 0);
                        if (!result_ready) rx_hold = $urandom_range(1, 10);
                    end
                endcase
            end
        end
    end

    task automatic send_sample(input logic [31:0] word, input logic first);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                item_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_valid = 1'b1;
        item.sample = word;
        item.start_req = first;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // Sends one container: the length header, then the payload if it is at
    // most 64 bytes and the block will accept it, else the header alone (two
    // samples if it does not fit). A non-negative cut stops it after cut samples.
    task automatic send_container(input logic [31:0] len, input int cut);
        bit          stream[$];
        int          hs;
        int          nsamp;
        int          s;
        int          j;
        logic [63:0] need;
        logic [7:0]  chunk;
        logic [7:0]  pay;
        logic [31:0] word;
        hs = (LENGTH_BITS + cur_n - 1) / cur_n;
        need = 64'(hs) + (64'(len) * 8 + cur_n - 1) / cur_n;
        for (j = 0; j < LENGTH_BITS; j++) stream.push_back(len[8 * (j / 8) + 7 - j % 8]);
        while (stream.size() < hs * cur_n) stream.push_back($urandom_range(0, 1));
        nsamp = hs;
        if (len != 0 && len <= cap_cfg && need <= 64'(sc_cfg) && len <= 64)
        begin
            repeat (len)
            begin
                pay = $urandom;
                for (j = 7; j >= 0; j--) stream.push_back(pay[j]);
            end
            while (stream.size() % cur_n != 0) stream.push_back($urandom_range(0, 1));
            nsamp = stream.size() / cur_n;
        end
        if (sc_cfg < hs) nsamp = 2;
        if (cut >= 0 && cut < nsamp) nsamp = cut;
        for (s = 0; s < nsamp; s++)
        begin
            chunk = '0;
            for (j = 0; j < cur_n; j++) chunk = {chunk[6:0], stream[s * cur_n + j]};
            word = $urandom;
            word[7:0] = (word[7:0] & (8'hFF << cur_n)) | chunk;
            send_sample(word, s == 0);
            items_sent++;
        end
        containers++;
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [3:0] bps, input logic [31:0] sc,
                              input logic [31:0] cap);
        cfg_write(CFG_BITS_PER_SAMPLE, {28'($urandom), bps});
        cfg_write(CFG_SAMPLE_COUNT, sc);
        cfg_write(CFG_MAX_PAYLOAD_BYTES, cap);
        cur_n = (bps == 0) ? 1 : (bps > MAX_BPS) ? MAX_BPS : bps;
        sc_cfg = sc;
        cap_cfg = cap;
        settings++;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [3:0]  bps;
        logic [31:0] sc;
        logic [31:0] cap;
        logic [31:0] len;
        logic [63:0] fit;
        logic [63:0] upper;
        int unsigned n;
        int unsigned hs;
        int unsigned kind;
        int          ncont;
        int          c;
        int          cut;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        containers = 0;
        settings = 1;
        burst_left = 0;
        gaps_on = 1'b0;
        cur_n = 1;
        sc_cfg = '0;
        cap_cfg = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the reset register values.
        send_container(32'd3, -1);
        wait_idle();
        set_config(4'd8, 32'd100, 32'd2);
        send_container(32'd0, -1);
        send_container(32'd3, -1);
        send_container(32'd2, -1);
        wait_idle();
        set_config(4'd15, 32'd5, 32'hFFFF_FFFF);
        send_container(32'hFFFF_FFFF, -1);
        send_container(32'd2, 1);
        send_container(32'd1, -1);

        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            bps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            n = (bps == 0) ? 1 : (bps > MAX_BPS) ? MAX_BPS : bps;
            hs = (LENGTH_BITS + n - 1) / n;
            case ($urandom_range(0, 9))
                0: sc = 32'hFFFF_FFFF;
                1: sc = $urandom_range(0, hs + 2);
                default: sc = hs + ($urandom_range(1, 12) * 8 + n - 1) / n + $urandom_range(0, 3);
            endcase
            case ($urandom_range(0, 5))
                0: cap = 32'hFFFF_FFFF;
                1: cap = '0;
                default: cap = $urandom_range(1, 12);
            endcase
            set_config(bps, sc, cap);
            gaps_on = ($urandom_range(0, 3) != 0);
            fit = (sc_cfg >= hs) ? ((64'(sc_cfg) - hs) * cur_n) / 8 : 64'd0;
            ncont = $urandom_range(2, 6);
            for (c = 0; c < ncont; c++)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 6)
                begin
                    upper = 12;
                    if (64'(cap_cfg) < upper) upper = cap_cfg;
                    if (fit < upper) upper = fit;
                    len = (upper >= 1) ? $urandom_range(1, upper) : $urandom_range(0, 3);
                end
                else if (kind == 7)
                begin
                    len = '0;
                end
                else if (kind == 8)
                begin
                    case ($urandom_range(0, 2))
                        0: len = (cap_cfg != 32'hFFFF_FFFF) ? cap_cfg + 1 : cap_cfg;
                        1: len = (fit < 64'hFFFF_FFFF) ? 32'(fit + 1) : 32'hFFFF_FFFF;
                        default: len = (cap_cfg > 12) ? 32'd12 : cap_cfg;
                    endcase
                end
                else
                begin
                    len = $urandom;
                    if (sc_cfg == 32'hFFFF_FFFF || len < 256) len = 32'hFFFF_FFFF;
                end
                cut = (c < ncont - 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1;
                send_container(len, cut);
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3)) send_sample($urandom, 1'b0);
                end
            end
        end

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("summary: %0d samples in %0d containers under %0d register settings",
                 items_sent, containers, settings);
        $display("summary: %0d payload bytes and %0d status reports checked",
                 bytes_seen, reports_seen);
        if (failures == 0 && pending == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
